// ----- sv/sstq_pkg.sv -----
// ----------------------------------------------------------------------------
// sstq_pkg
// Shared types and constants for the stable sorted timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sstq_pkg;

  localparam int PRIO_W    = 32;
  localparam int TAG_W     = 16;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 7;
  localparam int IN_W      = 56;
  localparam int OUT_W     = 64;

  typedef enum logic [REQ_W-1:0] {
    REQ_SORTED = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_POP    = 2'd2,
    REQ_DELETE = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_READ,
    S_CHECK,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_head;
    logic scan_tail;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_t req;
    logic full;
    logic empty;
    logic last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- sv/stable_sorted_timer_queue.sv -----
// ----------------------------------------------------------------------------
// stable_sorted_timer_queue
// Ordered timer queue of up to DEPTH entries with stable sorted insert.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH entries of a 32-bit priority and a 16-bit tag,
// head first, in a memory with one read port and one write port. A sorted
// insert lands just before the first entry of strictly greater priority, so
// equal priorities keep their arrival order; append goes to the tail, pop
// returns the head, and delete removes the first entry whose tag matches.
// Each request item yields exactly one result item carrying a status, the
// popped entry (zero otherwise) and the entry count afterward. Requests are
// handled one at a time. A sorted insert walks the entries from the head to
// the tail, pop and delete walk all of them, an append visits only the tail
// slot, and a rejected request skips the walk. The walk is a read-then-check
// loop over the entry memory, with a READ and a CHECK state per entry because
// the memory read data is registered. A finished result sits in an output
// register, so the next request item is taken while the previous result is
// still waiting on m_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_sorted_timer_queue
  import sstq_pkg::*;
#(
  parameter int DEPTH = 64
)
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // s_tdata, from bit 0: req_type[1:0], entry_priority[33:2],
  // entry_tag[49:34], zero fill[55:50].
  input  wire logic [IN_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // m_tdata, from bit 0: status[1:0], out_priority[33:2], out_tag[49:34],
  // entry_count[56:50], zero fill[63:57].
  output logic [OUT_W-1:0]      m_tdata
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // The controller only sequences; all storage and arithmetic are in the
  // datapath.
  sstq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (s_tready)
  );

  sstq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

// ----- sv/sstq_ctrl.sv -----
// ----------------------------------------------------------------------------
// sstq_ctrl
// Sequencer for one queue request: decode, read/check loop, result.
// ----------------------------------------------------------------------------
`default_nettype none

module sstq_ctrl
  import sstq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd,
  output logic           in_ready
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        case (stat.req)
          REQ_SORTED, REQ_APPEND: state_next = stat.full ? S_FIN : S_READ;
          REQ_POP, REQ_DELETE:    state_next = stat.empty ? S_FIN : S_READ;
          default:                state_next = S_FIN;
        endcase
      end
      S_READ:  state_next = S_CHECK;
      S_CHECK: state_next = stat.last ? S_FIN : S_READ;
      S_FIN: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EVAL: begin
        // Appends go straight to the tail; everything else scans from the head.
        if (stat.req == REQ_APPEND) begin
          cmd.scan_tail = 1'b1;
        end else begin
          cmd.scan_head = 1'b1;
        end
      end
      S_READ:  cmd = '0;
      S_CHECK: cmd.step = 1'b1;
      S_FIN:   cmd.finish = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/sstq_dp.sv -----
// ----------------------------------------------------------------------------
// sstq_dp
// Entry memory, scan index, carry register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sstq_dp
  import sstq_pkg::*;
#(
  parameter int DEPTH = 64
)
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ctrl_cmd_t        cmd,
  output dp_stat_t              stat,
  input  wire logic [IN_W-1:0]  in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [OUT_W-1:0]      out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t mem [DEPTH];
  entry_t rdata;

  req_t              req_r;
  logic [PRIO_W-1:0] prio_r;
  logic [TAG_W-1:0]  tag_r;
  entry_t            carry;
  logic              found;
  logic [PRIO_W-1:0] pop_prio;
  logic [TAG_W-1:0]  pop_tag;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;

  logic          ins;
  logic          at_tail;
  logic          hit;
  logic          match;
  logic [CW-1:0] idx_m1;
  logic [CW-1:0] count_m1;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;

  status_t       res_status;
  logic [CW-1:0] res_count;
  logic [CW+CNT_OUT_W-1:0] res_count_ext;

  assign ins      = (req_r == REQ_SORTED) || (req_r == REQ_APPEND);
  assign at_tail  = (idx == count);
  assign idx_m1   = idx - CW'(1);
  assign count_m1 = count - CW'(1);
  assign hit      = found || at_tail || (rdata.prio > prio_r);
  assign match    = (req_r == REQ_POP) || (rdata.tag == tag_r);

  // Insert: from the insertion point on, each slot takes the carried entry
  // and hands its old entry forward. Removal: after the victim, each entry
  // moves down by one slot.
  assign we    = cmd.step && (ins ? hit : found);
  assign waddr = ins ? idx[AW-1:0] : idx_m1[AW-1:0];
  assign wdata = ins ? carry : rdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[idx[AW-1:0]];
  end

  assign stat.req      = req_r;
  assign stat.full     = (count == CW'(DEPTH));
  assign stat.empty    = (count == '0);
  assign stat.last     = ins ? at_tail : (idx == count_m1);
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= req_t'(in_data[REQ_W-1:0]);
      prio_r   <= in_data[REQ_W +: PRIO_W];
      tag_r    <= in_data[REQ_W+PRIO_W +: TAG_W];
      carry    <= {in_data[REQ_W +: PRIO_W], in_data[REQ_W+PRIO_W +: TAG_W]};
      found    <= 1'b0;
      pop_prio <= '0;
      pop_tag  <= '0;
    end
    if (cmd.scan_head) begin
      idx   <= '0;
      found <= 1'b0;
    end
    if (cmd.scan_tail) begin
      idx   <= count;
      found <= 1'b1;
    end
    if (cmd.step) begin
      idx <= idx + CW'(1);
      if (ins) begin
        if (hit) begin
          carry <= rdata;
          found <= 1'b1;
        end
      end else if (!found && match) begin
        found <= 1'b1;
        if (req_r == REQ_POP) begin
          pop_prio <= rdata.prio;
          pop_tag  <= rdata.tag;
        end
      end
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_count  = count;
    case (req_r)
      REQ_SORTED, REQ_APPEND: begin
        if (stat.full) begin
          res_status = ST_FULL;
        end else begin
          res_count = count + CW'(1);
        end
      end
      REQ_POP: begin
        if (stat.empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_count = count_m1;
        end
      end
      REQ_DELETE: begin
        if (found) begin
          res_count = count_m1;
        end else begin
          res_status = ST_NOTFOUND;
        end
      end
      default: res_status = ST_OK;
    endcase
  end

  assign res_count_ext = {{CNT_OUT_W{1'b0}}, res_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count     <= res_count;
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= {{(OUT_W-STAT_W-PRIO_W-TAG_W-CNT_OUT_W){1'b0}},
                   res_count_ext[CNT_OUT_W-1:0], pop_tag, pop_prio, res_status};
    end
  end

endmodule

`default_nettype wire

// ----- sv/sstq_checker.sv -----
// ----------------------------------------------------------------------------
// sstq_checker
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sstq_checker
  import sstq_pkg::*;
#(
  parameter int DEPTH = 64
)
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Requests are taken one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken back to back");

  // A failed request carries zero entry fields.
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[49:2] == '0))
    else $error("entry fields not zero on a failed request");

  // A dropped insert reports a full queue.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == ST_FULL) && (DEPTH < 128)
      |-> (m_tdata[56:50] == DEPTH[6:0]))
    else $error("full status with count below depth");

  // The count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (DEPTH < 128) |-> (m_tdata[56:50] <= DEPTH[6:0]))
    else $error("entry count above depth");

endmodule

bind stable_sorted_timer_queue sstq_checker #(
  .DEPTH (DEPTH)
) u_sstq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the stable sorted timer queue.
// ----------------------------------------------------------------------------
// The bench keeps a shadow copy of the queue in plain arrays. Every request
// item accepted on the slave side is applied to the shadow copy. The reply
// that the copy gives is queued, and each reply item that leaves the master
// side is checked field by field against the oldest queued reply.
// The stimulus opens with a short hand-written sequence: empty pop, deletes
// that miss, extreme priorities and tags, ties on priority and a duplicate
// tag. Random blocks follow. Some of them push the queue to full and keep
// inserting, some drain it to empty, and some mix both. Tags come mostly from
// a small pool, so that deletes find their target. Both sides idle at random.
// Once, the reply side holds off for a long stretch while requests keep
// coming, so the block must stall its input.
// ----------------------------------------------------------------------------

module testbench;
  import sstq_pkg::*;

  localparam int QUEUE_DEPTH  = 64;
  localparam int BLOCK_ITEMS  = 100;
  localparam int RANDOM_BLOCKS = 15;
  // A nearly full queue makes each sorted insert walk all of its entries. Add
  // the longest idle gap on each side and take the total several times over.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 600;
  localparam int HOLD_AT      = 200;
  localparam int MAX_PRINTS   = 40;

  typedef struct {
    req_t              req;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } request_t;

  typedef struct {
    status_t              status;
    logic [PRIO_W-1:0]    prio;
    logic [TAG_W-1:0]     tag;
    logic [CNT_OUT_W-1:0] count;
  } reply_t;

  logic            clk;
  logic            rst      = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata  = '0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  stable_sorted_timer_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Shadow copy of the queue, head at index 0.
  logic [PRIO_W-1:0] shadow_prio [QUEUE_DEPTH];
  logic [TAG_W-1:0]  shadow_tag  [QUEUE_DEPTH];
  int                shadow_count = 0;

  request_t request_backlog [$];
  reply_t   queued_replies  [$];
  request_t current_request;

  int total_requests   = 0;
  int requests_taken   = 0;
  int replies_seen     = 0;
  int error_count      = 0;
  int cycle_count      = 0;

  // Idle state of the request side and the reply side.
  int  tx_gap = 0;
  int  tx_calm = 0;
  int  rx_gap = 0;
  int  rx_calm = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("mismatch at reply %0d: %s", replies_seen, what);
    end
  endtask

  // Remove the entry at pos and close the hole toward the head.
  function automatic void close_gap(input int pos);
    for (int i = pos; i + 1 < shadow_count; i++) begin
      shadow_prio[i] = shadow_prio[i + 1];
      shadow_tag[i]  = shadow_tag[i + 1];
    end
    shadow_count--;
  endfunction

  // Apply one request to the shadow queue and return the reply it earns.
  function automatic reply_t apply_request(input request_t rq);
    reply_t rp;
    int     pos;
    rp.status = ST_OK;
    rp.prio   = '0;
    rp.tag    = '0;
    case (rq.req)
      REQ_SORTED, REQ_APPEND: begin
        if (shadow_count >= QUEUE_DEPTH) begin
          rp.status = ST_FULL;
        end else begin
          pos = shadow_count;
          if (rq.req == REQ_SORTED) begin
            // Skip every entry of lower or equal priority, so ties keep
            // their arrival order.
            pos = 0;
            while (pos < shadow_count && shadow_prio[pos] <= rq.prio) pos++;
          end
          for (int i = shadow_count; i > pos; i--) begin
            shadow_prio[i] = shadow_prio[i - 1];
            shadow_tag[i]  = shadow_tag[i - 1];
          end
          shadow_prio[pos] = rq.prio;
          shadow_tag[pos]  = rq.tag;
          shadow_count++;
        end
      end
      REQ_POP: begin
        if (shadow_count == 0) begin
          rp.status = ST_EMPTY;
        end else begin
          rp.prio = shadow_prio[0];
          rp.tag  = shadow_tag[0];
          close_gap(0);
        end
      end
      default: begin
        pos = 0;
        while (pos < shadow_count && shadow_tag[pos] != rq.tag) pos++;
        if (pos >= shadow_count) begin
          rp.status = ST_NOTFOUND;
        end else begin
          close_gap(pos);
        end
      end
    endcase
    rp.count = shadow_count[CNT_OUT_W-1:0];
    return rp;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PRIO_W-1:0] pick_priority();
    int r;
    r = $urandom_range(0, 99);
    // A narrow range makes ties frequent. The corners check unsigned order.
    if (r < 40) return $urandom_range(0, 15);
    if (r < 60) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h7FFF_FFFF;
        default: return 32'h8000_0000;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    int r;
    r = $urandom_range(0, 99);
    // Tags come mostly from a small pool, so deletes hit and duplicates occur.
    if (r < 60) return TAG_W'($urandom_range(0, 15));
    if (r < 75) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    return TAG_W'($urandom);
  endfunction

  task automatic add_request(input req_t req, input logic [PRIO_W-1:0] prio,
                             input logic [TAG_W-1:0] tag);
    request_t rq;
    rq.req  = req;
    rq.prio = prio;
    rq.tag  = tag;
    request_backlog.push_back(rq);
  endtask

  // Stimulus and end of run.
  initial begin
    int      mode;
    int      r;
    req_t    req;
    // Hand-written opening: the corner cases first, on a queue that is
    // small enough to follow by eye.
    add_request(REQ_POP,    32'd0,         16'd0);      // pop when empty
    add_request(REQ_DELETE, 32'd0,         16'd5);      // delete on empty
    add_request(REQ_SORTED, 32'hFFFF_FFFF, 16'hFFFF);
    add_request(REQ_SORTED, 32'h0000_0000, 16'h0000);
    add_request(REQ_SORTED, 32'd100,       16'd1);
    add_request(REQ_SORTED, 32'd100,       16'd2);      // tie lands after tag 1
    add_request(REQ_SORTED, 32'h8000_0000, 16'd3);      // above 100 as unsigned
    add_request(REQ_APPEND, 32'd5,         16'd4);      // tail, out of order
    add_request(REQ_SORTED, 32'd100,       16'd5);      // third tie at 100
    add_request(REQ_DELETE, 32'hFFFF_FFFF, 16'd2);      // delete from the middle
    add_request(REQ_DELETE, 32'd0,         16'd9);      // tag not present
    add_request(REQ_APPEND, 32'd0,         16'd1);      // duplicate tag
    add_request(REQ_DELETE, 32'd0,         16'd1);      // only the first match
    add_request(REQ_DELETE, 32'd0,         16'hFFFF);
    for (int i = 0; i < 6; i++) begin
      add_request(REQ_POP, 32'd0, 16'd0);              // drain past empty
    end

    // Random blocks. The first block fills the queue and keeps inserting
    // into it while it is full. The second drains it. After that the kind
    // of each block is random.
    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      if (b == 0) mode = 0;
      else if (b == 1) mode = 1;
      else mode = $urandom_range(0, 2);
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if ((mode == 0 && r < 85) || (mode == 1 && r < 15) ||
            (mode == 2 && r < 50)) begin
          req = ($urandom_range(0, 3) != 0) ? REQ_SORTED : REQ_APPEND;
        end else begin
          req = ($urandom_range(0, 9) < 6) ? REQ_POP : REQ_DELETE;
        end
        add_request(req, pick_priority(), pick_tag());
      end
    end
    total_requests = request_backlog.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (requests_taken < total_requests) @(posedge clk);
    while (queued_replies.size() != 0) @(posedge clk);
    // Let a late or extra reply show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Request driver. A request that the block accepts goes through the shadow
  // queue at once, and its reply is queued. The next request is offered after
  // a random gap. tvalid is assigned once per edge, so a request that follows
  // without a gap keeps tvalid high.
  always @(posedge clk) begin
    logic offer;
    offer = s_tvalid;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (tx_calm > 0) begin
        tx_calm--;
      end else if ($urandom_range(0, 499) == 0) begin
        tx_calm = $urandom_range(50, 300);
      end
      if (s_tvalid && s_tready) begin
        queued_replies.push_back(apply_request(current_request));
        requests_taken++;
        offer = 1'b0;
        tx_gap = (tx_calm > 0) ? 0 : idle_gap();
      end
      if (!offer) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (request_backlog.size() != 0) begin
          current_request = request_backlog.pop_front();
          s_tdata <= {{(IN_W - REQ_W - PRIO_W - TAG_W){1'b0}},
                      current_request.tag, current_request.prio,
                      current_request.req};
          offer = 1'b1;
        end
      end
      s_tvalid <= offer;
    end
  end

  // Reply-side readiness. Short random stalls, stretches with none, and one
  // long hold-off after a few hundred replies. During the hold-off the
  // driver goes on offering requests. The block fills its output register,
  // takes one more request and then has to drop s_tready.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_calm > 0) begin
        rx_calm--;
      end else if ($urandom_range(0, 499) == 0) begin
        rx_calm = $urandom_range(50, 300);
      end
      if (!hold_done && replies_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (rx_gap > 0) begin
        m_tready <= 1'b0;
        rx_gap--;
      end else begin
        m_tready <= 1'b1;
        if (rx_calm == 0 && $urandom_range(0, 5) == 0) rx_gap = idle_gap();
      end
    end
  end

  // Reply monitor: take every reply item off the master side and check each
  // field against the oldest queued reply.
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status = status_t'(m_tdata[1:0]);
      got.prio   = m_tdata[33:2];
      got.tag    = m_tdata[49:34];
      got.count  = m_tdata[56:50];
      if (queued_replies.size() == 0) begin
        report_mismatch("reply item with no request waiting for it");
      end else begin
        want = queued_replies.pop_front();
        if (got.status != want.status) begin
          report_mismatch($sformatf("status %s, wanted %s",
                                    got.status.name(), want.status.name()));
        end
        if (got.prio != want.prio) begin
          report_mismatch($sformatf("out_priority %h, wanted %h",
                                    got.prio, want.prio));
        end
        if (got.tag != want.tag) begin
          report_mismatch($sformatf("out_tag %h, wanted %h", got.tag, want.tag));
        end
        if (got.count != want.count) begin
          report_mismatch($sformatf("entry_count %0d, wanted %0d",
                                    got.count, want.count));
        end
      end
      replies_seen++;
    end
  end

  // Watchdog. A hang ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

// ----- files.f -----
sv/sstq_pkg.sv
sv/sstq_ctrl.sv
sv/sstq_dp.sv
sv/stable_sorted_timer_queue.sv
sv/sstq_checker.sv
sim/testbench.sv
